// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define KOT_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Next-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define KOT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/kot_pkg.sv
package kot_pkg;

    localparam int MAX_TEXT_DEF = 20;
    localparam int MAX_TEXT_HI  = 64;
    localparam int LEN_W        = $clog2(MAX_TEXT_HI + 1);
    localparam int KIND_W       = 5;
    localparam int BYTE_W       = 8;
    localparam int TEXT_INDEX_W = 5;
    localparam int NUM_KW       = 5;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [KIND_W-1:0] K_IF      = 5'd0;
    localparam logic [KIND_W-1:0] K_ELSEIF  = 5'd1;
    localparam logic [KIND_W-1:0] K_ELSE    = 5'd2;
    localparam logic [KIND_W-1:0] K_REPEAT  = 5'd3;
    localparam logic [KIND_W-1:0] K_OUTPUT  = 5'd4;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd5;
    localparam logic [KIND_W-1:0] K_INT     = 5'd6;
    localparam logic [KIND_W-1:0] K_EQEQ    = 5'd7;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd8;
    localparam logic [KIND_W-1:0] K_NE      = 5'd9;
    localparam logic [KIND_W-1:0] K_AND     = 5'd10;
    localparam logic [KIND_W-1:0] K_OR      = 5'd11;
    localparam logic [KIND_W-1:0] K_LE      = 5'd12;
    localparam logic [KIND_W-1:0] K_LT      = 5'd13;
    localparam logic [KIND_W-1:0] K_GE      = 5'd14;
    localparam logic [KIND_W-1:0] K_GT      = 5'd15;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd16;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd17;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd18;
    localparam logic [KIND_W-1:0] K_SLASH   = 5'd19;
    localparam logic [KIND_W-1:0] K_PERCENT = 5'd20;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd21;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd22;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd23;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd24;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd25;
    localparam logic [KIND_W-1:0] K_EOF     = 5'd26;
    localparam logic [KIND_W-1:0] K_INVALID = 5'd27;

    // Commands passed from the front end to the back end.
    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_TOKEN = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // For a store, len is the write position; for a text flush, the length.
    // LEN_W covers the largest supported text limit.
    typedef struct packed {
        logic [1:0]        op;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              trunc;
        logic              last;
    } t_cmd;

    function automatic logic [2:0] kw_len(input logic [KIND_W-1:0] k);
        logic [2:0] n;
        case (k)
            K_IF:     n = 3'd2;
            K_ELSEIF: n = 3'd6;
            K_ELSE:   n = 3'd4;
            K_REPEAT: n = 3'd6;
            K_OUTPUT: n = 3'd6;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic [KIND_W-1:0] k,
                                                  input logic [2:0] p);
        logic [5:0][BYTE_W-1:0] w;
        w = '0;
        case (k)
            K_IF: begin
                w[0] = "I"; w[1] = "F";
            end
            K_ELSEIF: begin
                w[0] = "E"; w[1] = "L"; w[2] = "S"; w[3] = "E"; w[4] = "I"; w[5] = "F";
            end
            K_ELSE: begin
                w[0] = "E"; w[1] = "L"; w[2] = "S"; w[3] = "E";
            end
            K_REPEAT: begin
                w[0] = "R"; w[1] = "E"; w[2] = "P"; w[3] = "E"; w[4] = "A"; w[5] = "T";
            end
            K_OUTPUT: begin
                w[0] = "O"; w[1] = "U"; w[2] = "T"; w[3] = "P"; w[4] = "U"; w[5] = "T";
            end
            default: w = '0;
        endcase
        return (p < 3'd6) ? w[p] : '0;
    endfunction

endpackage

// File: hw/rtl/kot_ifs.sv
interface kot_char_if;
    logic                       valid;
    logic                       ready;
    logic [kot_pkg::BYTE_W-1:0] char_byte;
    logic                       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface kot_token_if;
    logic                             valid;
    logic                             ready;
    logic [kot_pkg::KIND_W-1:0]       token_kind;
    logic [kot_pkg::BYTE_W-1:0]       text_byte;
    logic [kot_pkg::TEXT_INDEX_W-1:0] text_index;
    logic                             token_end;
    logic                             text_truncated;
    logic                             last_result;

    modport source (output valid, output token_kind, output text_byte, output text_index,
                    output token_end, output text_truncated, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input text_byte, input text_index,
                    input token_end, input text_truncated, input last_result,
                    output ready);
endinterface

// File: hw/rtl/kot_front.sv
module kot_front #(
    parameter int MAX_TEXT = kot_pkg::MAX_TEXT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kot_char_if.sink      i_char_if,
    output logic          o_push,
    output kot_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam int KW    = kot_pkg::KIND_W;
    localparam int LW    = kot_pkg::LEN_W;
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_TEXT);

    localparam logic [3:0] MODE_IDLE   = 4'd0;
    localparam logic [3:0] MODE_IDENT  = 4'd1;
    localparam logic [3:0] MODE_NUMBER = 4'd2;
    localparam logic [3:0] MODE_EQ     = 4'd3;
    localparam logic [3:0] MODE_BANG   = 4'd4;
    localparam logic [3:0] MODE_AMP    = 4'd5;
    localparam logic [3:0] MODE_PIPE   = 4'd6;
    localparam logic [3:0] MODE_LESS   = 4'd7;
    localparam logic [3:0] MODE_MORE   = 4'd8;

    function automatic kot_pkg::t_cmd tok_cmd(input logic [KW-1:0] kind);
        kot_pkg::t_cmd t;
        t      = '0;
        t.op   = kot_pkg::CMD_TOKEN;
        t.kind = kind;
        return t;
    endfunction

    logic [3:0]                 r_mode, n_mode;
    logic [CNT_W-1:0]           r_len, n_len;
    logic                       r_ovf, n_ovf;
    logic [kot_pkg::NUM_KW-1:0] r_kw, n_kw;
    logic                       r_pend_valid;
    kot_pkg::t_cmd              r_pend;

    logic [kot_pkg::BYTE_W-1:0] c;
    logic                       accept;
    logic                       is_letter, is_digit, is_space;
    logic [kot_pkg::NUM_KW-1:0] kw_first, kw_next;
    logic                       kw_hit;
    logic [KW-1:0]              kw_kind;
    logic                       st_valid, st_text;
    logic [3:0]                 st_mode;
    kot_pkg::t_cmd              st_cmd;
    kot_pkg::t_cmd              fl_cmd;
    logic [kot_pkg::BYTE_W-1:0] pair_char;
    logic [KW-1:0]              pair_kind;
    logic                       take_start;
    logic                       f_valid, t_valid, t_prod;
    kot_pkg::t_cmd              f_cmd, t_cmd, a_cmd, p_cmd;
    logic                       a_valid, b_valid;

    assign c         = i_char_if.char_byte;
    assign i_char_if.ready = !r_pend_valid && !i_full;
    assign accept    = i_char_if.valid && i_char_if.ready;
    assign is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    assign is_digit  = (c >= "0" && c <= "9");
    assign is_space  = (c == " ") || (c >= 8'd9 && c <= 8'd13);

    // Keyword candidates are narrowed one character at a time, so no read of
    // the text store is needed when an identifier ends.
    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = kot_pkg::K_IDENT;
        for (int i = 0; i < kot_pkg::NUM_KW; i++) begin
            kw_first[i] = (c == kot_pkg::kw_char(KW'(i), 3'd0));
            kw_next[i]  = r_kw[i]
                       && (r_len < CNT_W'(kot_pkg::kw_len(KW'(i))))
                       && (c == kot_pkg::kw_char(KW'(i), r_len[2:0]));
            if (!kw_hit && !r_ovf && r_kw[i]
                && (r_len == CNT_W'(kot_pkg::kw_len(KW'(i))))) begin
                kw_hit  = 1'b1;
                kw_kind = KW'(i);
            end
        end
    end

    // What a character does when no token is pending.
    always_comb begin
        st_valid = 1'b0;
        st_text  = 1'b0;
        st_mode  = MODE_IDLE;
        st_cmd   = tok_cmd(kot_pkg::K_INVALID);
        if (is_space) begin
            st_valid = 1'b0;
        end else if (is_letter || is_digit) begin
            st_valid    = 1'b1;
            st_text     = 1'b1;
            st_mode     = is_letter ? MODE_IDENT : MODE_NUMBER;
            st_cmd      = '0;
            st_cmd.op   = kot_pkg::CMD_STORE;
            st_cmd.data = c;
        end else begin
            st_valid = 1'b1;
            case (c)
                "=": begin st_valid = 1'b0; st_mode = MODE_EQ;   end
                "!": begin st_valid = 1'b0; st_mode = MODE_BANG; end
                "&": begin st_valid = 1'b0; st_mode = MODE_AMP;  end
                "|": begin st_valid = 1'b0; st_mode = MODE_PIPE; end
                "<": begin st_valid = 1'b0; st_mode = MODE_LESS; end
                ">": begin st_valid = 1'b0; st_mode = MODE_MORE; end
                "+": st_cmd = tok_cmd(kot_pkg::K_PLUS);
                "-": st_cmd = tok_cmd(kot_pkg::K_MINUS);
                "*": st_cmd = tok_cmd(kot_pkg::K_STAR);
                "/": st_cmd = tok_cmd(kot_pkg::K_SLASH);
                "%": st_cmd = tok_cmd(kot_pkg::K_PERCENT);
                "(": st_cmd = tok_cmd(kot_pkg::K_LPAREN);
                ")": st_cmd = tok_cmd(kot_pkg::K_RPAREN);
                "{": st_cmd = tok_cmd(kot_pkg::K_LBRACE);
                "}": st_cmd = tok_cmd(kot_pkg::K_RBRACE);
                ";": st_cmd = tok_cmd(kot_pkg::K_SEMI);
                default: st_cmd = tok_cmd(kot_pkg::K_INVALID);
            endcase
        end
    end

    // Flush of the pending token, and the two-character form it may take.
    always_comb begin
        fl_cmd    = tok_cmd(kot_pkg::K_INVALID);
        pair_char = "=";
        pair_kind = kot_pkg::K_EQEQ;
        unique case (r_mode) inside
            MODE_IDENT: begin
                if (kw_hit) begin
                    fl_cmd = tok_cmd(kw_kind);
                end else begin
                    fl_cmd       = '0;
                    fl_cmd.op    = kot_pkg::CMD_TEXT;
                    fl_cmd.kind  = kot_pkg::K_IDENT;
                    fl_cmd.len   = LW'(r_len);
                    fl_cmd.trunc = r_ovf;
                end
            end
            MODE_NUMBER: begin
                fl_cmd       = '0;
                fl_cmd.op    = kot_pkg::CMD_TEXT;
                fl_cmd.kind  = kot_pkg::K_INT;
                fl_cmd.len   = LW'(r_len);
                fl_cmd.trunc = r_ovf;
            end
            MODE_EQ: begin
                fl_cmd    = tok_cmd(kot_pkg::K_ASSIGN);
                pair_kind = kot_pkg::K_EQEQ;
            end
            MODE_BANG: pair_kind = kot_pkg::K_NE;
            MODE_AMP: begin
                pair_char = "&";
                pair_kind = kot_pkg::K_AND;
            end
            MODE_PIPE: begin
                pair_char = "|";
                pair_kind = kot_pkg::K_OR;
            end
            MODE_LESS: begin
                fl_cmd    = tok_cmd(kot_pkg::K_LT);
                pair_kind = kot_pkg::K_LE;
            end
            MODE_MORE: begin
                fl_cmd    = tok_cmd(kot_pkg::K_GT);
                pair_kind = kot_pkg::K_GE;
            end
            default: fl_cmd = tok_cmd(kot_pkg::K_INVALID);
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_len      = r_len;
        n_ovf      = r_ovf;
        n_kw       = r_kw;
        f_valid    = 1'b0;
        t_valid    = 1'b0;
        t_cmd      = '0;
        take_start = 1'b0;
        if (i_char_if.end_of_input) begin
            f_valid = (r_mode != MODE_IDLE);
            t_valid = 1'b1;
            t_cmd   = tok_cmd(kot_pkg::K_EOF);
            n_mode  = MODE_IDLE;
            n_len   = '0;
            n_ovf   = 1'b0;
        end else begin
            unique case (r_mode) inside
                MODE_IDENT, MODE_NUMBER: begin
                    if ((r_mode == MODE_IDENT && is_letter)
                        || (r_mode == MODE_NUMBER && is_digit)) begin
                        if (r_len < LEN_MAX) begin
                            t_valid     = 1'b1;
                            t_cmd.op    = kot_pkg::CMD_STORE;
                            t_cmd.data  = c;
                            t_cmd.len   = LW'(r_len);
                            n_len       = r_len + CNT_W'(1);
                            n_kw        = kw_next;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        f_valid    = 1'b1;
                        take_start = 1'b1;
                    end
                end
                MODE_EQ, MODE_BANG, MODE_AMP, MODE_PIPE, MODE_LESS, MODE_MORE: begin
                    if (c == pair_char) begin
                        t_valid = 1'b1;
                        t_cmd   = tok_cmd(pair_kind);
                        n_mode  = MODE_IDLE;
                    end else begin
                        f_valid    = 1'b1;
                        take_start = 1'b1;
                    end
                end
                default: take_start = 1'b1;
            endcase
            if (take_start) begin
                t_valid = st_valid;
                t_cmd   = st_cmd;
                n_mode  = st_mode;
                if (st_text) begin
                    n_len = CNT_W'(1);
                    n_ovf = 1'b0;
                    n_kw  = kw_first;
                end
            end
        end
    end

    // The flush carries the item's last-result mark unless a token follows it.
    always_comb begin
        t_prod     = t_valid && (t_cmd.op != kot_pkg::CMD_STORE);
        f_cmd      = fl_cmd;
        f_cmd.last = !t_prod;
        a_cmd      = f_valid ? f_cmd : t_cmd;
        if (!f_valid) begin
            a_cmd.last = 1'b1;
        end
        p_cmd      = t_cmd;
        p_cmd.last = 1'b1;
        a_valid = f_valid || t_valid;
        b_valid = f_valid && t_valid;
    end

    assign o_push = r_pend_valid ? !i_full : (accept && a_valid);
    assign o_cmd  = r_pend_valid ? r_pend : a_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_kw         <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode       <= n_mode;
                r_len        <= n_len;
                r_ovf        <= n_ovf;
                r_kw         <= n_kw;
                r_pend_valid <= b_valid;
            end else if (r_pend_valid && !i_full) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= p_cmd;
        end
    end

endmodule

// File: hw/rtl/kot_cmd_fifo.sv
module kot_cmd_fifo #(
    parameter int DEPTH = kot_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kot_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output kot_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    kot_pkg::t_cmd   r_slot [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/kot_back.sv
module kot_back #(
    parameter int MAX_TEXT = kot_pkg::MAX_TEXT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kot_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    kot_token_if.source   o_token_if
);

    localparam int IW = $clog2(MAX_TEXT);
    localparam int CW = $clog2(MAX_TEXT + 1);
    localparam int XW = kot_pkg::TEXT_INDEX_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TEXT = 1'b1;

    logic [kot_pkg::BYTE_W-1:0] r_text [MAX_TEXT];
    logic [kot_pkg::BYTE_W-1:0] r_rdata;

    logic                        r_state, n_state;
    logic [IW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_tlen;
    logic [kot_pkg::KIND_W-1:0]  r_tkind;
    logic                        r_ttrunc, r_tlast;

    logic                        r_out_valid;
    logic [kot_pkg::KIND_W-1:0]  r_out_kind;
    logic [kot_pkg::BYTE_W-1:0]  r_out_byte;
    logic [XW-1:0]               r_out_index;
    logic                        r_out_end, r_out_trunc, r_out_last;

    logic                        out_free, load, start_text, wr_en, text_end;
    logic [IW-1:0]               rd_addr;
    logic [kot_pkg::KIND_W-1:0]  ld_kind;
    logic [kot_pkg::BYTE_W-1:0]  ld_byte;
    logic [XW-1:0]               ld_index;
    logic                        ld_end, ld_trunc, ld_last;

    assign out_free = !r_out_valid || o_token_if.ready;
    assign text_end = ((CW'(r_idx) + CW'(1)) == r_tlen);

    // During a text run the read address runs one entry ahead of the output
    // register, so one byte leaves per cycle while the sink keeps up.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        rd_addr    = r_idx;
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        load       = 1'b0;
        start_text = 1'b0;
        ld_kind    = i_cmd.kind;
        ld_byte    = '0;
        ld_index   = '0;
        ld_end     = 1'b1;
        ld_trunc   = 1'b0;
        ld_last    = i_cmd.last;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        kot_pkg::CMD_STORE: begin
                            wr_en = 1'b1;
                            o_pop = 1'b1;
                        end
                        kot_pkg::CMD_TOKEN: begin
                            if (out_free) begin
                                load  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                        kot_pkg::CMD_TEXT: begin
                            o_pop      = 1'b1;
                            start_text = 1'b1;
                            n_state    = ST_TEXT;
                            n_idx      = '0;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            ST_TEXT: begin
                ld_kind  = r_tkind;
                ld_byte  = r_rdata;
                ld_index = XW'(r_idx);
                ld_end   = text_end;
                ld_trunc = r_ttrunc;
                ld_last  = r_tlast && text_end;
                if (out_free) begin
                    load = 1'b1;
                    if (text_end) begin
                        n_state = ST_IDLE;
                        rd_addr = '0;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_text[i_cmd.len[IW-1:0]] <= i_cmd.data;
        end
        r_rdata <= r_text[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_token_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_text) begin
            r_tlen   <= i_cmd.len[CW-1:0];
            r_tkind  <= i_cmd.kind;
            r_ttrunc <= i_cmd.trunc;
            r_tlast  <= i_cmd.last;
        end
        if (load) begin
            r_out_kind  <= ld_kind;
            r_out_byte  <= ld_byte;
            r_out_index <= ld_index;
            r_out_end   <= ld_end;
            r_out_trunc <= ld_trunc;
            r_out_last  <= ld_last;
        end
    end

    assign o_token_if.valid          = r_out_valid;
    assign o_token_if.token_kind     = r_out_kind;
    assign o_token_if.text_byte      = r_out_byte;
    assign o_token_if.text_index     = r_out_index;
    assign o_token_if.token_end      = r_out_end;
    assign o_token_if.text_truncated = r_out_trunc;
    assign o_token_if.last_result    = r_out_last;

endmodule

// File: hw/rtl/keyword_operator_tokenizer_top.sv
// Streaming tokenizer: one source character per input transfer, tokens out as
// result transfers. The front end classifies each character and queues at most
// two commands for it; a character that both ends a token and starts another
// leaves its second command pending and holds off the next character until it
// is queued. Whitespace and letters or digits that extend a run give no result.
// The back end sends one result per cycle while the sink keeps up and no store
// or text setup comes between: one for each keyword, operator or other token,
// and one for each stored text byte of an identifier or integer. Each text run
// starts with a setup step for the first read of the text RAM, and the back end
// writes each stored character into it. The command queue lets the input keep
// flowing while a text run drains. There is no clearing pass after reset.
`include "assert_macros.svh"

module keyword_operator_tokenizer_top #(
    parameter int MAX_TEXT  = kot_pkg::MAX_TEXT_DEF,
    parameter int CMD_DEPTH = kot_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kot_char_if.sink    i_char_if,
    kot_token_if.source o_token_if
);

    logic          w_push, w_full, w_pop, w_empty;
    kot_pkg::t_cmd w_cmd_in, w_cmd_out;

    kot_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_if (i_char_if),
        .o_push    (w_push),
        .o_cmd     (w_cmd_in),
        .i_full    (w_full)
    );

    kot_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    kot_back #(
        .MAX_TEXT (MAX_TEXT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd_out),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_token_if (o_token_if)
    );

    `KOT_ASSERT(a_no_push_when_full, !(w_push && w_full), "command pushed into a full queue")
    `KOT_ASSERT(a_mid_token_is_text, !(o_token_if.valid && !o_token_if.token_end) || o_token_if.token_kind == kot_pkg::K_IDENT || o_token_if.token_kind == kot_pkg::K_INT, "non-final result of a token without text")
    `KOT_ASSERT(a_last_ends_token, !(o_token_if.valid && o_token_if.last_result) || o_token_if.token_end, "last result of an item inside a token")
    `KOT_ASSERT_NEXT(a_text_run_gapless, o_token_if.valid && o_token_if.ready && !o_token_if.token_end, o_token_if.valid, "gap inside a text run")

endmodule
